// ----- hw/rtl/cidht_pkg.sv -----
// Shared types, constants and hash helper for the connection ID hash table.
// No dependencies.
package cidht_pkg;

  localparam int TableSlotsDef = 1024;
  localparam int MaxConnectionsDef = 256;
  localparam int MaxIdBytes = 20;
  localparam logic [31:0] FnvOffset = 32'd2166136261;
  localparam logic [31:0] FnvPrime = 32'd16777619;
  localparam logic [3:0] LimitReset = 4'd8;

  typedef enum logic [1:0] {
    ACT_ADD = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_LOOKUP = 2'd2,
    ACT_DONE = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_FULL = 2'd1,
    ST_LIMIT = 2'd2,
    ST_MISS = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    KIND_EMPTY = 2'd0,
    KIND_LIVE = 2'd1,
    KIND_TOMB = 2'd2,
    KIND_SPARE = 2'd3
  } kind_t;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] conn_handle;
    logic [4:0] id_length;
    logic [63:0] id_word0;
    logic [63:0] id_word1;
    logic [31:0] id_word2;
    logic done_flag;
  } in_word_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] found_handle;
    logic hit;
  } out_word_t;

  // A hashed, masked command as it travels from front to back.
  typedef struct packed {
    logic [1:0] action;
    logic [7:0] conn_handle;
    logic [4:0] id_length;
    logic [159:0] key;
    logic done_flag;
    logic [31:0] hash;
  } cmd_t;

  localparam int CmdWidth = $bits(cmd_t);

  function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [7:0] b);
    logic [31:0] x;
    x = h ^ {24'd0, b};
    return x * FnvPrime;
  endfunction

endpackage

// ----- hw/rtl/cidht_ram.sv -----
// Generic single-port RAM with registered read.
// No dependencies.
module cidht_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ----- hw/rtl/cidht_front.sv -----
// Front end: accepts commands, masks the ID and hashes it one byte a cycle.
// Depends on cidht_pkg.
module cidht_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  cidht_pkg::in_word_t in_word,
  output logic              busy,
  output logic              cmd_valid,
  output cidht_pkg::cmd_t   cmd,
  input  logic              cmd_ready
);
  import cidht_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_HASH, S_HOLD} fstate_t;

  fstate_t state_r, state_nxt;
  cmd_t cmd_r, cmd_nxt;
  logic [4:0] idx_r, idx_nxt;
  logic [4:0] len_c;
  logic [159:0] mask_c;
  logic [7:0] byte_c;

  always_comb begin
    len_c = (in_word.id_length > 5'(MaxIdBytes)) ? 5'(MaxIdBytes) : in_word.id_length;
    for (int i = 0; i < 20; i++) begin
      mask_c[i*8 +: 8] = (5'(i) < len_c) ? 8'hff : 8'h00;
    end
  end

  assign byte_c = cmd_r.key[{idx_r, 3'b000} +: 8];

  always_comb begin
    state_nxt = state_r;
    cmd_nxt = cmd_r;
    idx_nxt = idx_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt.action = in_word.action;
          cmd_nxt.conn_handle = in_word.conn_handle;
          cmd_nxt.id_length = len_c;
          cmd_nxt.key = {in_word.id_word2, in_word.id_word1, in_word.id_word0} & mask_c;
          cmd_nxt.done_flag = in_word.done_flag;
          cmd_nxt.hash = FnvOffset;
          idx_nxt = '0;
          state_nxt = S_HASH;
        end
      end
      S_HASH: begin
        if (idx_r < cmd_r.id_length) begin
          cmd_nxt.hash = fnv_step(cmd_r.hash, byte_c);
          idx_nxt = idx_r + 5'd1;
        end else begin
          state_nxt = S_HOLD;
        end
      end
      S_HOLD: begin
        if (cmd_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r <= idx_nxt;
    end
    cmd_r <= cmd_nxt;
  end

  assign busy = (state_r != S_IDLE);
  assign cmd_valid = (state_r == S_HOLD);
  assign cmd = cmd_r;
endmodule

// ----- hw/rtl/cidht_queue.sv -----
// Two-entry queue between the front end and the table engine.
// Depends on cidht_pkg.
module cidht_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  input  cidht_pkg::cmd_t push_cmd,
  output logic            push_ready,
  output logic            pop_valid,
  output cidht_pkg::cmd_t pop_cmd,
  input  logic            pop_ready
);
  import cidht_pkg::*;

  cmd_t q_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic rd_r, wr_r;
  logic push, pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid = (cnt_r != 2'd0);
  assign pop_cmd = q_r[rd_r];
  assign push = push_valid && push_ready;
  assign pop = pop_valid && pop_ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r <= 1'b0;
      wr_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_r <= ~wr_r;
      end
      if (pop) begin
        rd_r <= ~rd_r;
      end
    end
    if (push) begin
      q_r[wr_r] <= push_cmd;
    end
  end
endmodule

// ----- hw/rtl/cidht_engine.sv -----
// Table engine: clears the tables after reset, then probes the slot memory.
// Depends on cidht_pkg and cidht_ram.
module cidht_engine #(
  parameter int TableSlots = cidht_pkg::TableSlotsDef,
  parameter int MaxConnections = cidht_pkg::MaxConnectionsDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [3:0]         limit,
  input  logic               cmd_valid,
  input  cidht_pkg::cmd_t    cmd,
  output logic               cmd_ready,
  output logic               out_strobe,
  output cidht_pkg::out_word_t out_word,
  output logic               clearing
);
  import cidht_pkg::*;

  localparam int SlotBits = $clog2(TableSlots);
  localparam int ConnBits = $clog2(MaxConnections);
  localparam int SlotWidth = 2 + 8 + 160 + 5;
  localparam int ConnWidth = 5;
  localparam int ClrMax = (TableSlots > MaxConnections) ? TableSlots : MaxConnections;
  localparam int ClrBits = $clog2(ClrMax + 1);

  typedef enum logic [2:0] {
    E_CLEAR, E_IDLE, E_CONN, E_READ, E_CHECK, E_OWN, E_OUT
  } estate_t;

  estate_t state_r, state_nxt;
  logic [ClrBits-1:0] clr_r, clr_nxt;
  logic [SlotBits-1:0] slot_r, slot_nxt;
  logic [SlotBits:0] cnt_r, cnt_nxt;
  cmd_t c_r, c_nxt;
  out_word_t res_r, res_nxt;
  logic [3:0] held_r, held_nxt;
  logic done_r, done_nxt;
  logic [7:0] own_r, own_nxt;

  logic s_we, c_we;
  logic [SlotBits-1:0] s_addr;
  logic [ConnBits-1:0] c_addr;
  logic [SlotWidth-1:0] s_wdata, s_rdata;
  logic [ConnWidth-1:0] c_wdata, c_rdata;
  logic [1:0] rk;
  logic [7:0] rowner;
  logic [159:0] rkey;
  logic [4:0] rlen;
  logic [3:0] rheld;
  logic rdone;
  logic hvalid, ovalid, match, last, adv;
  logic [ConnBits-1:0] hidx;

  assign {rk, rowner, rkey, rlen} = s_rdata;
  assign {rheld, rdone} = c_rdata;
  assign hvalid = ({24'd0, c_r.conn_handle} < 32'(MaxConnections));
  assign ovalid = ({24'd0, rowner} < 32'(MaxConnections));
  assign hidx = ConnBits'(c_r.conn_handle);
  assign match = (rk == KIND_LIVE) && (rlen == c_r.id_length) && (rkey == c_r.key);
  assign last = (cnt_r == (SlotBits+1)'(TableSlots - 1));

  cidht_ram #(.Width(SlotWidth), .Depth(TableSlots)) u_slots (
    .clk(clk), .we(s_we), .addr(s_addr), .wdata(s_wdata), .rdata(s_rdata)
  );
  cidht_ram #(.Width(ConnWidth), .Depth(MaxConnections)) u_conns (
    .clk(clk), .we(c_we), .addr(c_addr), .wdata(c_wdata), .rdata(c_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    clr_nxt = clr_r;
    slot_nxt = slot_r;
    cnt_nxt = cnt_r;
    c_nxt = c_r;
    res_nxt = res_r;
    held_nxt = held_r;
    done_nxt = done_r;
    own_nxt = own_r;
    adv = 1'b0;
    s_we = 1'b0;
    c_we = 1'b0;
    s_addr = slot_r;
    c_addr = hidx;
    s_wdata = {KIND_EMPTY, 8'd0, 160'd0, 5'd0};
    c_wdata = '0;
    cmd_ready = 1'b0;
    unique case (state_r)
      E_CLEAR: begin
        if (clr_r < ClrBits'(TableSlots)) begin
          s_we = 1'b1;
          s_addr = clr_r[SlotBits-1:0];
        end
        if (clr_r < ClrBits'(MaxConnections)) begin
          c_we = 1'b1;
          c_addr = clr_r[ConnBits-1:0];
        end
        clr_nxt = clr_r + 1'b1;
        if (clr_r == ClrBits'(ClrMax - 1)) begin
          state_nxt = E_IDLE;
        end
      end
      E_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          c_nxt = cmd;
          slot_nxt = cmd.hash[SlotBits-1:0];
          cnt_nxt = '0;
          state_nxt = E_CONN;
        end
      end
      E_CONN: begin
        // The connection entry and the home slot are read in this cycle.
        state_nxt = E_READ;
        res_nxt = '{status: ST_MISS, found_handle: 8'd0, hit: 1'b0};
      end
      E_READ: begin
        held_nxt = rheld;
        done_nxt = rdone;
        unique case (action_t'(c_r.action))
          ACT_ADD: begin
            if (!hvalid || rheld >= limit) begin
              res_nxt.status = ST_LIMIT;
              state_nxt = E_OUT;
            end else begin
              res_nxt.status = ST_FULL;
              state_nxt = E_CHECK;
            end
          end
          ACT_REMOVE: state_nxt = hvalid ? E_CHECK : E_OUT;
          ACT_LOOKUP: state_nxt = E_CHECK;
          ACT_DONE: begin
            if (hvalid) begin
              c_we = 1'b1;
              c_wdata = {rheld, c_r.done_flag};
            end
            res_nxt.status = ST_OK;
            state_nxt = E_OUT;
          end
          default: state_nxt = E_OUT;
        endcase
      end
      E_CHECK: begin
        // Read data holds slot_r; a slot that ends nothing moves on to the next.
        adv = 1'b1;
        unique case (action_t'(c_r.action))
          ACT_ADD: begin
            if (rk != KIND_LIVE) begin
              s_we = 1'b1;
              s_wdata = {KIND_LIVE, c_r.conn_handle, c_r.key, c_r.id_length};
              c_we = 1'b1;
              c_wdata = {held_r + 4'd1, done_r};
              res_nxt.status = ST_OK;
              adv = 1'b0;
              state_nxt = E_OUT;
            end
          end
          ACT_REMOVE: begin
            if (rk == KIND_EMPTY) begin
              adv = 1'b0;
              state_nxt = E_OUT;
            end else if (match && rowner == c_r.conn_handle) begin
              s_we = 1'b1;
              s_wdata = {KIND_TOMB, rowner, rkey, rlen};
              c_we = 1'b1;
              c_wdata = {(held_r != 4'd0) ? held_r - 4'd1 : 4'd0, done_r};
              res_nxt.status = ST_OK;
              adv = 1'b0;
              state_nxt = E_OUT;
            end
          end
          ACT_LOOKUP: begin
            if (rk == KIND_EMPTY) begin
              adv = 1'b0;
              state_nxt = E_OUT;
            end else if (match && ovalid) begin
              c_addr = ConnBits'(rowner);
              own_nxt = rowner;
              adv = 1'b0;
              state_nxt = E_OWN;
            end
          end
          default: begin
            adv = 1'b0;
            state_nxt = E_OUT;
          end
        endcase
      end
      E_OWN: begin
        if (!rdone) begin
          res_nxt = '{status: ST_OK, found_handle: own_r, hit: 1'b1};
          state_nxt = E_OUT;
        end else begin
          adv = 1'b1;
        end
      end
      E_OUT: state_nxt = E_IDLE;
      default: state_nxt = E_IDLE;
    endcase
    if (adv) begin
      slot_nxt = slot_r + 1'b1;
      s_addr = slot_r + 1'b1;
      cnt_nxt = cnt_r + 1'b1;
      state_nxt = last ? E_OUT : E_CHECK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= E_CLEAR;
      clr_r <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_nxt;
    end
    slot_r <= slot_nxt;
    cnt_r <= cnt_nxt;
    c_r <= c_nxt;
    res_r <= res_nxt;
    held_r <= held_nxt;
    done_r <= done_nxt;
    own_r <= own_nxt;
  end

  assign out_strobe = (state_r == E_OUT);
  assign out_word = res_r;
  assign clearing = (state_r == E_CLEAR);
endmodule

// ----- hw/rtl/connection_id_hash_table_core.sv -----
// Top level of the connection ID hash table: config register, front end,
// queue and table engine. Depends on cidht_pkg and the cidht_* modules.
//
// Usage: raise start with a command word while busy is low; the command is
// taken at that edge. The front end hashes one ID byte per cycle, the ID
// length being taken as at most 20, and keeps busy high until the queue has
// taken the word, so a new word is taken only once busy is low again. The
// word then passes a two-entry queue to the table engine, which probes one
// slot per cycle, pausing on a lookup match to read the owner's entry.
// The engine reads the connection entry and the home slot, checks slots in
// turn until one ends the command, and then shows the result on out_valid;
// limit, done-mark and bad-handle commands other than lookups skip the slot
// checks. The table size must be a power of two.
// After reset the engine clears both memories, one entry per cycle, up to
// the larger of TABLE_SLOTS and MAX_CONNECTIONS; commands queue meanwhile.
// The receiver cannot stall: each result is taken in the cycle it shows.
// The limit register sits at address 0 of the APB port, reset value 8.
module connection_id_hash_table_core #(
  parameter int TABLE_SLOTS = cidht_pkg::TableSlotsDef,
  parameter int MAX_CONNECTIONS = cidht_pkg::MaxConnectionsDef
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  cidht_pkg::in_word_t  in_word,
  output logic                 out_valid,
  output cidht_pkg::out_word_t out_word,
  input  logic                 cfg_psel,
  input  logic                 cfg_penable,
  input  logic                 cfg_pwrite,
  input  logic                 cfg_paddr,
  input  logic [31:0]          cfg_pwdata,
  output logic [31:0]          cfg_prdata,
  output logic                 cfg_pready
);
  import cidht_pkg::*;

  logic [3:0] limit_r;
  logic f_valid, f_ready, q_valid, q_ready, clearing;
  cmd_t f_cmd, q_cmd;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = cfg_paddr ? 32'd0 : {28'd0, limit_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LimitReset;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && !cfg_paddr) begin
      limit_r <= cfg_pwdata[3:0];
    end
  end

  cidht_front u_front (
    .clk(clk), .rst_n(rst_n), .start(start), .in_word(in_word), .busy(busy),
    .cmd_valid(f_valid), .cmd(f_cmd), .cmd_ready(f_ready)
  );

  cidht_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push_valid(f_valid), .push_cmd(f_cmd),
    .push_ready(f_ready), .pop_valid(q_valid), .pop_cmd(q_cmd), .pop_ready(q_ready)
  );

  cidht_engine #(.TableSlots(TABLE_SLOTS), .MaxConnections(MAX_CONNECTIONS)) u_engine (
    .clk(clk), .rst_n(rst_n), .limit(limit_r), .cmd_valid(q_valid), .cmd(q_cmd),
    .cmd_ready(q_ready), .out_strobe(out_valid), .out_word(out_word), .clearing(clearing)
  );

  a_no_out_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !out_valid) else $error("result during clear");
  a_hit_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.hit |-> out_word.status == ST_OK) else $error("hit without ok");
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("start not taken");
endmodule
